@@ rtl/core/fcirc_pkg.sv @@
// Shared types and constants for the circular-store FIR filter.
// No dependencies; used by the MAC unit, the top level and the checker.
`default_nettype none

package fcirc_pkg;

	// Sample and coefficient format (Q1.15)
	localparam int SAMP_W = 16;
	localparam int FRAC_W = 15;
	localparam int CIDX_W = 3;

	// Digit-serial multiplier: coefficient enters four bits a cycle
	localparam int DIG_W  = 4;
	localparam int DIG_N  = SAMP_W / DIG_W;
	localparam int DIG_CW = $clog2(DIG_N);

	// Accumulator holds the exact sum of up to eight Q2.30 products
	localparam int ACC_W = 35;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// Accumulator control from the sequencer
	typedef struct packed {
		logic clr;
		logic en;
	} mac_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/fcirc_mac.sv @@
// Digit-serial multiply-accumulate with round-to-nearest and saturation.
// Depends on fcirc_pkg.
`default_nettype none

module fcirc_mac (
	input  wire logic                                  clk,
	input  wire fcirc_pkg::mac_ctl_t                   ctl,
	input  wire logic signed [fcirc_pkg::SAMP_W-1:0]   samp,
	input  wire logic        [fcirc_pkg::DIG_W-1:0]    digit,
	input  wire logic        [fcirc_pkg::DIG_CW-1:0]   dig,
	output logic signed      [fcirc_pkg::SAMP_W-1:0]   res
);

	localparam int AW = fcirc_pkg::ACC_W;
	localparam int SW = fcirc_pkg::SAMP_W;
	localparam int DW = fcirc_pkg::DIG_W;
	localparam logic [fcirc_pkg::DIG_CW-1:0] DIG_TOP = fcirc_pkg::DIG_CW'(fcirc_pkg::DIG_N - 1);
	localparam logic signed [AW-1:0] RND    = AW'(1) <<< (fcirc_pkg::FRAC_W - 1);
	localparam logic signed [AW-1:0] SAT_HI = AW'((1 << (SW - 1)) - 1);
	localparam logic signed [AW-1:0] SAT_LO = -(AW'(1) <<< (SW - 1));

	logic signed [DW:0]      digit_s;
	logic signed [SW+DW:0]   pp;
	logic signed [AW-1:0]    pp_ext;
	logic signed [AW-1:0]    pp_sh;
	logic signed [AW-1:0]    acc_q;
	logic signed [AW-1:0]    rnd;
	logic signed [AW-1:0]    quo;

	// Top digit carries the coefficient sign; lower digits are unsigned
	assign digit_s = {(dig == DIG_TOP) & digit[DW-1], digit};
	assign pp      = samp * digit_s;
	assign pp_ext  = AW'(pp);
	assign pp_sh   = pp_ext <<< (dig * DW);

	// Accumulate one partial product per cycle while en is high
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	// Round half up, drop fraction bits, clamp to 16 bits
	assign rnd = acc_q + RND;
	assign quo = rnd >>> fcirc_pkg::FRAC_W;

	always_comb begin
		if (quo > SAT_HI) begin
			res = SAT_HI[SW-1:0];
		end else if (quo < SAT_LO) begin
			res = SAT_LO[SW-1:0];
		end else begin
			res = quo[SW-1:0];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/fir_filter_circular.sv @@
// Top level of the circular-store FIR filter: coefficient registers, sample
// ring, sequencer and output register. Depends on fcirc_pkg and fcirc_mac.
//
// Usage:
//   Configuration: cfg_we writes cfg_data into coefficient cfg_index (tap k
//   weights the sample k steps back). Indexes at TAPS and above are dropped.
//   Write only while the filter is idle.
//   Input: a word is taken at a clock edge with in_valid high and in_stall
//   low. in_stall is high for as long as a word is being filtered.
//   Output: out_sample is held with out_valid until an edge with out_stall
//   low. A new input word is accepted while a result waits to be taken.
// Sequencing:
//   The multiplier takes one 4-bit coefficient digit per cycle, tap by tap,
//   and the fraction is rounded off combinationally at the MAC output once
//   the last tap is in. The result is then loaded into the output register
//   and the filter goes idle; a new word is taken only after that.
//   If the previous result is still stalled, the finished word waits in the
//   rounding stage and the filter stays busy.
// Reset:
//   arst_n clears coefficients, the sample ring, the write slot and the
//   output valid flag at once.
`default_nettype none

module fir_filter_circular #(
	parameter int TAPS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [fcirc_pkg::CIDX_W-1:0]        cfg_index,
	input  wire logic [fcirc_pkg::SAMP_W-1:0]        cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [fcirc_pkg::SAMP_W-1:0] in_sample,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [fcirc_pkg::SAMP_W-1:0]      out_sample
);

	localparam int SW     = fcirc_pkg::SAMP_W;
	localparam int DW     = fcirc_pkg::DIG_W;
	localparam int SLOT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam logic [SLOT_W-1:0] LAST = SLOT_W'(TAPS - 1);
	localparam logic [fcirc_pkg::DIG_CW-1:0] DIG_LAST = fcirc_pkg::DIG_CW'(fcirc_pkg::DIG_N - 1);

	fcirc_pkg::state_t        state_q;
	fcirc_pkg::mac_ctl_t      mac_ctl;
	logic signed [SW-1:0]     coef_q [TAPS];
	logic signed [SW-1:0]     ring_q [TAPS];
	logic [SLOT_W-1:0]        slot_q;
	logic [SLOT_W-1:0]        pos_q;
	logic [SLOT_W-1:0]        tap_q;
	logic [fcirc_pkg::DIG_CW-1:0] dig_q;
	logic signed [SW-1:0]     samp_q;
	logic [SW-1:0]            coef_sh_q;
	logic                     out_valid_q;
	logic signed [SW-1:0]     out_sample_q;
	logic signed [SW-1:0]     mac_res;
	logic                     in_acc;
	logic                     last_dig;
	logic                     out_free;
	logic [SLOT_W-1:0]        pos_nxt;
	logic [SLOT_W-1:0]        tap_nxt;
	logic                     cfg_hit;

	assign in_stall   = (state_q != fcirc_pkg::ST_IDLE);
	assign in_acc     = in_valid & ~in_stall;
	assign last_dig   = (dig_q == DIG_LAST);
	assign out_free   = ~out_valid_q | ~out_stall;
	assign pos_nxt    = (pos_q == '0) ? LAST : pos_q - 1'b1;
	assign tap_nxt    = (tap_q == LAST) ? '0 : tap_q + 1'b1;
	assign cfg_hit    = cfg_we & ({1'b0, cfg_index} < (fcirc_pkg::CIDX_W + 1)'(TAPS));
	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

	// Coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) coef_q[i] <= '0;
		end else if (cfg_hit) begin
			coef_q[cfg_index[SLOT_W-1:0]] <= cfg_data;
		end
	end

	// Sample ring: store the accepted word at the write slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) ring_q[i] <= '0;
		end else if (in_acc) begin
			ring_q[slot_q] <= in_sample;
		end
	end

	// Sequencer: step digits, then taps walking back through the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcirc_pkg::ST_IDLE;
			slot_q  <= '0;
			pos_q   <= '0;
			tap_q   <= '0;
			dig_q   <= '0;
		end else begin
			case (state_q)
				fcirc_pkg::ST_IDLE: begin
					if (in_acc) begin
						pos_q   <= slot_q;
						tap_q   <= '0;
						dig_q   <= '0;
						slot_q  <= (slot_q == LAST) ? '0 : slot_q + 1'b1;
						state_q <= fcirc_pkg::ST_RUN;
					end
				end
				fcirc_pkg::ST_RUN: begin
					dig_q <= dig_q + 1'b1;
					if (last_dig) begin
						tap_q <= tap_nxt;
						pos_q <= pos_nxt;
						if (tap_q == LAST) begin
							state_q <= fcirc_pkg::ST_DONE;
						end
					end
				end
				fcirc_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= fcirc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fcirc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Operand registers: sample held per tap, coefficient shifted a digit per cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			samp_q    <= in_sample;
			coef_sh_q <= coef_q[0];
		end else if (state_q == fcirc_pkg::ST_RUN) begin
			if (last_dig) begin
				samp_q    <= ring_q[pos_nxt];
				coef_sh_q <= coef_q[tap_nxt];
			end else begin
				coef_sh_q <= coef_sh_q >> DW;
			end
		end
	end

	assign mac_ctl.clr = in_acc;
	assign mac_ctl.en  = (state_q == fcirc_pkg::ST_RUN);

	fcirc_mac u_mac (
		.clk   (clk),
		.ctl   (mac_ctl),
		.samp  (samp_q),
		.digit (coef_sh_q[DW-1:0]),
		.dig   (dig_q),
		.res   (mac_res)
	);

	// Output register: load when the slot is free, drop on handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == fcirc_pkg::ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == fcirc_pkg::ST_DONE) && out_free) begin
			out_sample_q <= mac_res;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/fcirc_chk.sv @@
// Port-level checker for the circular-store FIR filter, bound to the top level.
// Depends on fcirc_pkg and fir_filter_circular.
`default_nettype none

module fcirc_chk (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_stall,
	input wire logic                                out_valid,
	input wire logic                                out_stall,
	input wire logic signed [fcirc_pkg::SAMP_W-1:0] out_sample
);

	// An accepted word makes the filter busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> ##1 in_stall ##1 in_stall)
		else $error("filter not busy after accepting a word");

	// A new result appears only at the end of a busy period
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

	// Leaving busy always hands a result to the output
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("went idle without a result");

	// Stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_sample)))
		else $error("stalled output word changed");

endmodule

bind fir_filter_circular fcirc_chk u_fcirc_chk (.*);

`default_nettype wire
